/* rtl/core/cpa_pkg.sv */
package cpa_pkg;

  localparam int KIND_BITS  = 2;
  localparam int OWNER_W    = 8;
  localparam int COUNT_W    = 14;
  localparam int FIRST_W    = 13;
  localparam int START_W    = 13;
  localparam int BOUND_W    = 14;

  localparam logic [BOUND_W-1:0] RESERVED_RESET = 14'd4096;

  localparam logic [KIND_BITS-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_OWNER = 2'd2;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [OWNER_W-1:0]   owner;
    logic [COUNT_W-1:0]   page_count;
    logic [FIRST_W-1:0]   first_page;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [START_W-1:0] start_page;
  } res_t;

endpackage

/* rtl/core/cpa_page_ram.sv */
module cpa_page_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13,
  parameter int DW    = 9
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/cpa_ctrl.sv */
module cpa_ctrl #(
  parameter int PAGES      = 8192,
  parameter int OWNER_BITS = 8,
  localparam int PW = $clog2(PAGES),
  localparam int W  = ((PW > cpa_pkg::COUNT_W) ? PW : cpa_pkg::COUNT_W) + 1,
  localparam int DW = OWNER_BITS + 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           req_valid,
  output logic           req_ready,
  input  cpa_pkg::req_t  req,
  input  logic [W-1:0]   bound,
  output logic           res_valid,
  input  logic           res_ready,
  output cpa_pkg::res_t  res,
  output logic           mem_rd_en,
  output logic [PW-1:0]  mem_rd_addr,
  input  logic [DW-1:0]  mem_rd_data,
  output logic           mem_wr_en,
  output logic [PW-1:0]  mem_wr_addr,
  output logic [DW-1:0]  mem_wr_data
);

  localparam logic [2:0] S_INIT     = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_ALLOC    = 3'd2;
  localparam logic [2:0] S_ALLOC_WR = 3'd3;
  localparam logic [2:0] S_FREE     = 3'd4;
  localparam logic [2:0] S_OWNER    = 3'd5;
  localparam logic [2:0] S_RESP     = 3'd6;

  localparam int CW = cpa_pkg::COUNT_W;
  localparam int RB = (int'(cpa_pkg::RESERVED_RESET) < PAGES) ?
                      int'(cpa_pkg::RESERVED_RESET) : PAGES;
  localparam logic [W-1:0] PAGES_W  = W'(PAGES);
  localparam logic [W-1:0] LAST_W   = W'(PAGES - 1);
  localparam logic [W-1:0] INIT_B_W = W'(RB);

  logic [2:0]            state_r, state_nxt;
  logic [W-1:0]          pos_r, pos_nxt;
  logic [CW-1:0]         rem_r, rem_nxt;
  logic [W-1:0]          run_r, run_nxt;
  logic [W-1:0]          rstart_r, rstart_nxt;
  logic [OWNER_BITS-1:0] who_r, who_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  rpend_r, rpend_nxt;
  logic [W-1:0]          rpos_r, rpos_nxt;
  cpa_pkg::res_t         res_r, res_nxt;

  logic                  rd_used;
  logic [OWNER_BITS-1:0] rd_owner;
  logic [W-1:0]          run_inc;
  logic [W-1:0]          run_first;
  logic                  found;

  assign rd_used   = mem_rd_data[0];
  assign rd_owner  = mem_rd_data[DW-1:1];
  assign run_inc   = run_r + W'(1);
  assign run_first = (run_r == '0) ? rpos_r : rstart_r;
  assign found     = rpend_r && !rd_used && (run_inc >= W'(cnt_r));

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);
  assign res       = res_r;

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    rem_nxt     = rem_r;
    run_nxt     = run_r;
    rstart_nxt  = rstart_r;
    who_nxt     = who_r;
    cnt_nxt     = cnt_r;
    rpend_nxt   = 1'b0;
    rpos_nxt    = pos_r;
    res_nxt     = res_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = pos_r[PW-1:0];
    mem_wr_en   = 1'b0;
    mem_wr_addr = pos_r[PW-1:0];
    mem_wr_data = '0;

    unique case (state_r)
      S_INIT: begin
        // Clearing pass: mark the reset boundary used, zero every owner tag.
        mem_wr_en   = 1'b1;
        mem_wr_data = {{OWNER_BITS{1'b0}}, (pos_r < INIT_B_W)};
        pos_nxt     = pos_r + W'(1);
        if (pos_r == LAST_W) begin
          state_nxt = S_IDLE;
          pos_nxt   = '0;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          who_nxt = OWNER_BITS'(req.owner);
          cnt_nxt = req.page_count;
          run_nxt = '0;
          res_nxt = '0;
          unique case (req.kind)
            cpa_pkg::KIND_ALLOC: begin
              pos_nxt = bound;
              if (req.page_count == '0 || bound >= PAGES_W) begin
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_ALLOC;
              end
            end
            cpa_pkg::KIND_FREE: begin
              pos_nxt    = W'(req.first_page);
              rem_nxt    = req.page_count;
              res_nxt.ok = 1'b1;
              state_nxt  = S_FREE;
            end
            cpa_pkg::KIND_OWNER: begin
              pos_nxt    = bound;
              res_nxt.ok = 1'b1;
              state_nxt  = (bound >= PAGES_W) ? S_RESP : S_OWNER;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_ALLOC: begin
        // Issue one read per cycle; the used bit returns from the RAM in the cycle after its read.
        if (pos_r < PAGES_W) begin
          mem_rd_en = 1'b1;
          rpend_nxt = 1'b1;
          pos_nxt   = pos_r + W'(1);
        end
        if (rpend_r) begin
          if (rd_used) begin
            run_nxt = '0;
          end else begin
            run_nxt    = run_inc;
            rstart_nxt = run_first;
          end
          if (found) begin
            state_nxt          = S_ALLOC_WR;
            pos_nxt            = run_first;
            rem_nxt            = cnt_r;
            rpend_nxt          = 1'b0;
            res_nxt.ok         = 1'b1;
            res_nxt.start_page = run_first[cpa_pkg::START_W-1:0];
          end else if (rpos_r == LAST_W) begin
            state_nxt = S_RESP;
          end
        end
      end
      S_ALLOC_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = {who_r, 1'b1};
        pos_nxt     = pos_r + W'(1);
        rem_nxt     = rem_r - CW'(1);
        if (rem_r == CW'(1)) begin
          state_nxt = S_RESP;
        end
      end
      S_FREE: begin
        if (rem_r == '0 || pos_r >= PAGES_W) begin
          state_nxt = S_RESP;
        end else begin
          mem_wr_en = (pos_r >= bound);
          pos_nxt   = pos_r + W'(1);
          rem_nxt   = rem_r - CW'(1);
        end
      end
      S_OWNER: begin
        if (pos_r < PAGES_W) begin
          mem_rd_en = 1'b1;
          rpend_nxt = 1'b1;
          pos_nxt   = pos_r + W'(1);
        end
        if (rpend_r) begin
          // Write back one entry behind the read pointer.
          mem_wr_addr = rpos_r[PW-1:0];
          mem_wr_en   = (rd_owner == who_r);
          if (rpos_r == LAST_W) begin
            state_nxt = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      pos_r   <= '0;
      rpend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      rpend_r <= rpend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    run_r    <= run_nxt;
    rstart_r <= rstart_nxt;
    who_r    <= who_nxt;
    cnt_r    <= cnt_nxt;
    rpos_r   <= rpos_nxt;
    res_r    <= res_nxt;
  end

  a_fail_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.ok |-> res.start_page == '0)
    else $error("failed result carries a nonzero start page");

  a_owner_wb_addr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OWNER && mem_wr_en |-> mem_wr_addr == $past(mem_rd_addr))
    else $error("owner sweep writes back to the wrong entry");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en && mem_rd_en |-> mem_wr_addr != mem_rd_addr)
    else $error("read and write hit the same entry in one cycle");

  a_alloc_wr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ALLOC_WR |-> rem_r != '0)
    else $error("allocation write phase entered with nothing to write");

endmodule

/* rtl/core/contiguous_page_allocator_core.sv */
// First-fit contiguous page allocator. Each page has a used bit and an owner tag held
// together in one single-port-read, single-port-write memory with a registered read
// port; the searches, tag writes and frees walk that memory one page per cycle. After
// reset the core runs a clearing pass (pages below 4096 marked used, all tags zero) and
// holds in_tready low until it ends; cfg writes are taken at any time, and the boundary
// written through cfg_data steers later searches and frees and any free in progress,
// never the stored bits. Allocate (tuser kind 0) scans from the boundary for the lowest
// run of page_count free pages, then writes the owner tag and used bit into each page of
// the run. Free range (kind 1) clears pages from first_page on, up to page_count pages
// or the end of the map, skipping reserved pages. Free by owner (kind 2) reads every
// page from the boundary up and clears each one whose owner tag matches. Zero-length or
// unsatisfiable allocations and kind 3 answer ok 0 and change nothing. One result
// follows each request, in order; a result held in the output register does not block
// acceptance of the next request.
module contiguous_page_allocator_core #(
  parameter int PAGES      = 8192,
  parameter int OWNER_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] owner, [21:8] page_count, [34:22] first_page
  input  logic [1:0]  in_tuser,   // [1:0] kind
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [12:0] start_page
  output logic [0:0]  out_tuser,  // [0] ok
  // Boundary register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [13:0] cfg_data    // [13:0] reserved_pages
);

  localparam int PW = $clog2(PAGES);
  localparam int W  = ((PW > cpa_pkg::COUNT_W) ? PW : cpa_pkg::COUNT_W) + 1;
  localparam int DW = OWNER_BITS + 1;
  localparam logic [W-1:0] PAGES_W = W'(PAGES);

  logic [cpa_pkg::BOUND_W-1:0] reserved_r;
  logic [W-1:0]                reserved_w;
  logic [W-1:0]                bound;

  cpa_pkg::req_t req;
  cpa_pkg::res_t res;
  logic          res_valid;
  logic          res_ready;

  logic                        out_valid_r;
  logic                        out_ok_r;
  logic [cpa_pkg::START_W-1:0] out_start_r;

  logic          mem_rd_en;
  logic [PW-1:0] mem_rd_addr;
  logic [DW-1:0] mem_rd_data;
  logic          mem_wr_en;
  logic [PW-1:0] mem_wr_addr;
  logic [DW-1:0] mem_wr_data;

  // Boundary register: always ready, a transfer overwrites it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_r <= cpa_pkg::RESERVED_RESET;
    end else if (cfg_valid) begin
      reserved_r <= cfg_data;
    end
  end

  // Clamp the boundary to the map size.
  assign reserved_w = W'(reserved_r);
  assign bound      = (reserved_w > PAGES_W) ? PAGES_W : reserved_w;

  // Unpack the request transfer.
  assign req.kind       = in_tuser;
  assign req.owner      = in_tdata[7:0];
  assign req.page_count = in_tdata[21:8];
  assign req.first_page = in_tdata[34:22];

  cpa_ctrl #(
    .PAGES      (PAGES),
    .OWNER_BITS (OWNER_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req         (req),
    .bound       (bound),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  cpa_page_ram #(
    .DEPTH (PAGES),
    .AW    (PW),
    .DW    (DW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Output register: load a result when the slot is empty or draining this cycle.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_ok_r    <= res.ok;
      out_start_r <= res.start_page;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_start_r};
  assign out_tuser  = out_ok_r;

endmodule
